/* rtl/core/q2hb_pkg.sv */
// ---------------------------------------------------------------------------
// q2hb_pkg: shared types and helpers for the Q2 hierarchical basis evaluator
// Basis numbering, lane operation control, wide arithmetic and rounding.
// ---------------------------------------------------------------------------
package q2hb_pkg;

	// Basis function numbers, in result order
	typedef enum logic [3:0] {
		B_VTX_SW  = 4'd0,
		B_VTX_SE  = 4'd1,
		B_VTX_NE  = 4'd2,
		B_VTX_NW  = 4'd3,
		B_EDGE_S  = 4'd4,
		B_EDGE_E  = 4'd5,
		B_EDGE_N  = 4'd6,
		B_EDGE_W  = 4'd7,
		B_CELL    = 4'd8
	} basis_t;

	// Rounding shift applied to a lane product
	typedef enum logic [1:0] {
		SH_NONE  = 2'd0,
		SH_TWO   = 2'd1,
		SH_FRAC  = 2'd2,
		SH_FRAC2 = 2'd3
	} shift_t;

	// Per-beat control for one arithmetic lane
	typedef struct packed {
		shift_t sh;    // rounding shift after the first product
		logic   s6;    // apply the sqrt(6) scaling step
		logic   ext3;  // sqrt(6)/8 when set, sqrt(6)/4 otherwise
	} lane_op_t;

	// sqrt(6) in Q22
	localparam int                 S6_W    = 25;
	localparam logic signed [24:0] S6_Q22  = 25'sd10273905;
	localparam int                 S6_FRAC = 22;
	// operand width of the sqrt(6) multiply (scaled terms stay below 2^32)
	localparam int                 S6_TW   = 34;

	localparam int WIDE_W = 72;
	typedef logic signed [WIDE_W-1:0] wide_t;
	localparam wide_t WIDE_ONE = 72'sd1;

	// Right shift with round to nearest, half away from zero
	function automatic wide_t rnd_shift(input wide_t v, input int unsigned s);
		wide_t half;
		wide_t bias;
		if (s == 0) begin
			half = '0;
			bias = '0;
		end else begin
			half = WIDE_ONE << (s - 1);
			bias = v[WIDE_W-1] ? (half - WIDE_ONE) : half;
		end
		return (v + bias) >>> s;
	endfunction

endpackage

/* rtl/core/q2_hier_basis_eval_unit.sv */
// ---------------------------------------------------------------------------
// q2_hier_basis_eval_unit: hierarchical Q2 basis evaluator, top level
// Value and element gradient of the nine hierarchical Legendre Q2 basis
// functions at one reference point, mapped through the inverse Jacobian.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one beat per point, carrying x_ref,
//   y_ref (COORD_FRAC_BITS fraction bits) and the Q16.16 inverse Jacobian.
//   Output channel (out_valid / out_stall): nine beats per point, basis_index
//   0..8 in order, last_basis set on the cell bubble (index 8).
//   Issue: the issue counter sends one basis function per cycle down the
//   pipeline while it is not stalled; the next point is taken on the cycle
//   the ninth function of the current one is issued.
//   Pipeline: item register, s1 squares, s2 operand select, s3..s6 three
//   arithmetic lanes (value, d/dx, d/dy), s7 clamp, s8 Jacobian products,
//   s9 sums, s10 rounding, s11 saturation into the output register.
//   Stall: while out_stall holds a valid result, the whole pipeline freezes;
//   nothing is lost or repeated, and in_stall rises once the item register
//   is still busy.
//   Reset: arst_n clears all valid bits and the issue counter; no results
//   are pending afterwards.
// ---------------------------------------------------------------------------
module q2_hier_basis_eval_unit #(
	parameter int COORD_FRAC_BITS = 14
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [15:0]  x_ref,
	input  logic signed [15:0]  y_ref,
	input  logic signed [31:0]  jinv_00,
	input  logic signed [31:0]  jinv_01,
	input  logic signed [31:0]  jinv_10,
	input  logic signed [31:0]  jinv_11,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [3:0]          basis_index,
	output logic signed [15:0]  basis_value,
	output logic signed [31:0]  grad_x,
	output logic signed [31:0]  grad_y,
	output logic                last_basis
);

	localparam int F    = COORD_FRAC_BITS;
	// operand width: covers one +- x and the squared terms x^2 / one - one
	localparam int CW_A = (F > 16) ? F : 16;
	localparam int CW_Q = ((30 - F) > CW_A) ? (30 - F) : CW_A;
	localparam int VW   = CW_Q + 2;
	localparam int PW   = 2 * VW;
	localparam int NS   = 11;   // pipeline stages after the item register
	localparam int SW   = 65;   // width of a Jacobian dot product

	localparam logic signed [VW-1:0] ONE_V  = VW'(1 << F);
	localparam logic signed [VW-1:0] UNIT_V = VW'(1);

	localparam q2hb_pkg::lane_op_t OP_RND2  = '{sh: q2hb_pkg::SH_TWO,   s6: 1'b0, ext3: 1'b0};
	localparam q2hb_pkg::lane_op_t OP_RNDF  = '{sh: q2hb_pkg::SH_FRAC,  s6: 1'b0, ext3: 1'b0};
	localparam q2hb_pkg::lane_op_t OP_RNDF2 = '{sh: q2hb_pkg::SH_FRAC2, s6: 1'b0, ext3: 1'b0};
	localparam q2hb_pkg::lane_op_t OP_S6_8F = '{sh: q2hb_pkg::SH_FRAC,  s6: 1'b1, ext3: 1'b1};
	localparam q2hb_pkg::lane_op_t OP_S6_4F = '{sh: q2hb_pkg::SH_FRAC,  s6: 1'b1, ext3: 1'b0};
	localparam q2hb_pkg::lane_op_t OP_S6_8  = '{sh: q2hb_pkg::SH_NONE,  s6: 1'b1, ext3: 1'b1};

	typedef struct packed {
		logic signed [31:0] j00;
		logic signed [31:0] j01;
		logic signed [31:0] j10;
		logic signed [31:0] j11;
	} jinv_t;

	function automatic logic signed [15:0] sat_val(input q2hb_pkg::wide_t v);
		if (v > q2hb_pkg::wide_t'(32767)) begin
			return 16'sh7FFF;
		end else if (v < q2hb_pkg::wide_t'(-32768)) begin
			return 16'sh8000;
		end
		return 16'(v);
	endfunction

	// symmetric clamp of a reference gradient
	function automatic logic signed [31:0] sat_ref(input q2hb_pkg::wide_t v);
		if (v > q2hb_pkg::wide_t'(2147483647)) begin
			return 32'sh7FFFFFFF;
		end else if (v < q2hb_pkg::wide_t'(-2147483647)) begin
			return 32'sh80000001;
		end
		return 32'(v);
	endfunction

	function automatic logic signed [31:0] sat_out(input q2hb_pkg::wide_t v);
		if (v > q2hb_pkg::wide_t'(2147483647)) begin
			return 32'sh7FFFFFFF;
		end else if (v < q2hb_pkg::wide_t'(-2147483647) - q2hb_pkg::WIDE_ONE) begin
			return 32'sh80000000;
		end
		return 32'(v);
	endfunction

	// ---------------- item register and issue counter ----------------
	logic                item_vld_q;
	q2hb_pkg::basis_t    k_q;
	logic signed [15:0]  x_q;
	logic signed [15:0]  y_q;
	jinv_t               jm_q;

	logic [NS:1]         vld_q;
	logic                adv;
	logic                issue;
	logic                in_acc;

	// whole pipeline moves unless a finished result is held by the receiver
	assign adv      = !vld_q[NS] || !out_stall;
	assign issue    = item_vld_q && adv;
	assign in_stall = item_vld_q && !(issue && (k_q == q2hb_pkg::B_CELL));
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_q <= 1'b0;
			k_q        <= q2hb_pkg::B_VTX_SW;
		end else if (in_acc) begin
			item_vld_q <= 1'b1;
			k_q        <= q2hb_pkg::B_VTX_SW;
		end else if (issue) begin
			if (k_q == q2hb_pkg::B_CELL) begin
				item_vld_q <= 1'b0;
			end else begin
				k_q <= q2hb_pkg::basis_t'(k_q + 4'd1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q  <= x_ref;
			y_q  <= y_ref;
			jm_q <= '{j00: jinv_00, j01: jinv_01, j10: jinv_10, j11: jinv_11};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NS-1:1], issue};
		end
	end

	// ---------------- s1: squares ----------------
	q2hb_pkg::basis_t    k_s1;
	logic signed [15:0]  x_s1;
	logic signed [15:0]  y_s1;
	logic signed [31:0]  xx_s1;
	logic signed [31:0]  yy_s1;
	jinv_t               jm_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			k_s1  <= k_q;
			x_s1  <= x_q;
			y_s1  <= y_q;
			xx_s1 <= 32'(x_q) * 32'(x_q);
			yy_s1 <= 32'(y_q) * 32'(y_q);
			jm_s1 <= jm_q;
		end
	end

	// ---------------- s2: shape terms and operand select ----------------
	logic signed [VW-1:0] xe, ye, ta, tb, tc, td, qx, qy;
	logic signed [VW-1:0] vm1, vm2, xm1, xm2, ym1, ym2;
	q2hb_pkg::lane_op_t   vop, xop, yop;

	always_comb begin
		xe = VW'(x_s1);
		ye = VW'(y_s1);
		ta = ONE_V - xe;
		tb = ONE_V + xe;
		tc = ONE_V - ye;
		td = ONE_V + ye;
		qx = VW'(q2hb_pkg::rnd_shift(q2hb_pkg::wide_t'(xx_s1), F)) - ONE_V;
		qy = VW'(q2hb_pkg::rnd_shift(q2hb_pkg::wide_t'(yy_s1), F)) - ONE_V;

		vm1 = ta;  vm2 = tc;      vop = OP_RNDF2;
		xm1 = -tc; xm2 = UNIT_V;  xop = OP_RND2;
		ym1 = -ta; ym2 = UNIT_V;  yop = OP_RND2;
		case (k_s1)
			q2hb_pkg::B_VTX_SW: begin
				vm1 = ta;  vm2 = tc;     vop = OP_RNDF2;
				xm1 = -tc; xm2 = UNIT_V; xop = OP_RND2;
				ym1 = -ta; ym2 = UNIT_V; yop = OP_RND2;
			end
			q2hb_pkg::B_VTX_SE: begin
				vm1 = tb;  vm2 = tc;     vop = OP_RNDF2;
				xm1 = tc;  xm2 = UNIT_V; xop = OP_RND2;
				ym1 = -tb; ym2 = UNIT_V; yop = OP_RND2;
			end
			q2hb_pkg::B_VTX_NE: begin
				vm1 = tb;  vm2 = td;     vop = OP_RNDF2;
				xm1 = td;  xm2 = UNIT_V; xop = OP_RND2;
				ym1 = tb;  ym2 = UNIT_V; yop = OP_RND2;
			end
			q2hb_pkg::B_VTX_NW: begin
				vm1 = ta;  vm2 = td;     vop = OP_RNDF2;
				xm1 = -td; xm2 = UNIT_V; xop = OP_RND2;
				ym1 = ta;  ym2 = UNIT_V; yop = OP_RND2;
			end
			q2hb_pkg::B_EDGE_S: begin
				vm1 = qx;  vm2 = tc;     vop = OP_S6_8F;
				xm1 = xe;  xm2 = tc;     xop = OP_S6_4F;
				ym1 = -qx; ym2 = UNIT_V; yop = OP_S6_8;
			end
			q2hb_pkg::B_EDGE_E: begin
				vm1 = qy;  vm2 = tb;     vop = OP_S6_8F;
				xm1 = qy;  xm2 = UNIT_V; xop = OP_S6_8;
				ym1 = ye;  ym2 = tb;     yop = OP_S6_4F;
			end
			q2hb_pkg::B_EDGE_N: begin
				vm1 = qx;  vm2 = td;     vop = OP_S6_8F;
				xm1 = xe;  xm2 = td;     xop = OP_S6_4F;
				ym1 = qx;  ym2 = UNIT_V; yop = OP_S6_8;
			end
			q2hb_pkg::B_EDGE_W: begin
				vm1 = qy;  vm2 = ta;     vop = OP_S6_8F;
				xm1 = -qy; xm2 = UNIT_V; xop = OP_S6_8;
				ym1 = ye;  ym2 = ta;     yop = OP_S6_4F;
			end
			q2hb_pkg::B_CELL: begin
				vm1 = qx;       vm2 = qy; vop = OP_RNDF;
				xm1 = xe <<< 1; xm2 = qy; xop = OP_RNDF;
				ym1 = ye <<< 1; ym2 = qx; yop = OP_RNDF;
			end
			default: begin
				vm1 = ta;  vm2 = tc;     vop = OP_RNDF2;
				xm1 = -tc; xm2 = UNIT_V; xop = OP_RND2;
				ym1 = -ta; ym2 = UNIT_V; yop = OP_RND2;
			end
		endcase
	end

	q2hb_pkg::basis_t     k_s2, k_s3, k_s4, k_s5, k_s6;
	jinv_t                jm_s2, jm_s3, jm_s4, jm_s5, jm_s6;
	logic signed [VW-1:0] vm1_s2, vm2_s2, xm1_s2, xm2_s2, ym1_s2, ym2_s2;
	q2hb_pkg::lane_op_t   vop_s2, xop_s2, yop_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			k_s2   <= k_s1;
			jm_s2  <= jm_s1;
			vm1_s2 <= vm1;
			vm2_s2 <= vm2;
			vop_s2 <= vop;
			xm1_s2 <= xm1;
			xm2_s2 <= xm2;
			xop_s2 <= xop;
			ym1_s2 <= ym1;
			ym2_s2 <= ym2;
			yop_s2 <= yop;
			// side band follows the lanes through s3..s6
			k_s3   <= k_s2;
			jm_s3  <= jm_s2;
			k_s4   <= k_s3;
			jm_s4  <= jm_s3;
			k_s5   <= k_s4;
			jm_s5  <= jm_s4;
			k_s6   <= k_s5;
			jm_s6  <= jm_s5;
		end
	end

	// ---------------- s3..s6: value and reference gradient lanes ----------------
	logic signed [PW-1:0] val_res, dx_res, dy_res;

	q2hb_lane #(.COORD_FRAC_BITS(F), .OPW(VW)) u_lane_val (
		.clk     (clk),
		.advance (adv),
		.m1      (vm1_s2),
		.m2      (vm2_s2),
		.op      (vop_s2),
		.res     (val_res)
	);

	q2hb_lane #(.COORD_FRAC_BITS(F), .OPW(VW)) u_lane_dx (
		.clk     (clk),
		.advance (adv),
		.m1      (xm1_s2),
		.m2      (xm2_s2),
		.op      (xop_s2),
		.res     (dx_res)
	);

	q2hb_lane #(.COORD_FRAC_BITS(F), .OPW(VW)) u_lane_dy (
		.clk     (clk),
		.advance (adv),
		.m1      (ym1_s2),
		.m2      (ym2_s2),
		.op      (yop_s2),
		.res     (dy_res)
	);

	// ---------------- s7..s11: clamp, Jacobian map, saturate ----------------
	q2hb_pkg::basis_t    k_s7, k_s8, k_s9, k_s10, k_s11;
	logic signed [15:0]  val_s7, val_s8, val_s9, val_s10, val_s11;
	jinv_t               jm_s7;
	logic signed [31:0]  dx_s7, dy_s7;
	logic signed [63:0]  gx0_s8, gx1_s8, gy0_s8, gy1_s8;
	logic signed [SW-1:0] gxs_s9, gys_s9;
	logic signed [SW-1:0] gxr_s10, gyr_s10;
	logic signed [31:0]  gx_s11, gy_s11;

	always_ff @(posedge clk) begin
		if (adv) begin
			k_s7    <= k_s6;
			jm_s7   <= jm_s6;
			val_s7  <= sat_val(q2hb_pkg::wide_t'(val_res));
			dx_s7   <= sat_ref(q2hb_pkg::wide_t'(dx_res));
			dy_s7   <= sat_ref(q2hb_pkg::wide_t'(dy_res));

			k_s8    <= k_s7;
			val_s8  <= val_s7;
			gx0_s8  <= 64'(jm_s7.j00) * 64'(dx_s7);
			gx1_s8  <= 64'(jm_s7.j01) * 64'(dy_s7);
			gy0_s8  <= 64'(jm_s7.j10) * 64'(dx_s7);
			gy1_s8  <= 64'(jm_s7.j11) * 64'(dy_s7);

			k_s9    <= k_s8;
			val_s9  <= val_s8;
			gxs_s9  <= SW'(gx0_s8) + SW'(gx1_s8);
			gys_s9  <= SW'(gy0_s8) + SW'(gy1_s8);

			k_s10   <= k_s9;
			val_s10 <= val_s9;
			gxr_s10 <= SW'(q2hb_pkg::rnd_shift(q2hb_pkg::wide_t'(gxs_s9), F));
			gyr_s10 <= SW'(q2hb_pkg::rnd_shift(q2hb_pkg::wide_t'(gys_s9), F));

			k_s11   <= k_s10;
			val_s11 <= val_s10;
			gx_s11  <= sat_out(q2hb_pkg::wide_t'(gxr_s10));
			gy_s11  <= sat_out(q2hb_pkg::wide_t'(gyr_s10));
		end
	end

	assign out_valid   = vld_q[NS];
	assign basis_index = k_s11;
	assign basis_value = val_s11;
	assign grad_x      = gx_s11;
	assign grad_y      = gy_s11;
	assign last_basis  = (k_s11 == q2hb_pkg::B_CELL);

endmodule

/* rtl/core/q2hb_lane.sv */
// ---------------------------------------------------------------------------
// q2hb_lane: one arithmetic lane of the basis evaluator
// Four stages: product, rounding shift, sqrt(6) product, final rounding.
// ---------------------------------------------------------------------------
module q2hb_lane #(
	parameter int COORD_FRAC_BITS = 14,
	parameter int OPW             = 18
) (
	input  logic                     clk,
	input  logic                     advance,
	input  logic signed [OPW-1:0]    m1,
	input  logic signed [OPW-1:0]    m2,
	input  q2hb_pkg::lane_op_t       op,
	output logic signed [2*OPW-1:0]  res
);

	localparam int F   = COORD_FRAC_BITS;
	localparam int PW  = 2 * OPW;
	localparam int TW  = q2hb_pkg::S6_TW;
	localparam int P6W = TW + q2hb_pkg::S6_W;

	logic signed [PW-1:0]  prod_s3;
	q2hb_pkg::lane_op_t    op_s3;
	logic signed [PW-1:0]  t_s4;
	q2hb_pkg::lane_op_t    op_s4;
	logic signed [P6W-1:0] p6_s5;
	logic signed [PW-1:0]  t_s5;
	q2hb_pkg::lane_op_t    op_s5;
	logic signed [PW-1:0]  res_s6;

	logic signed [PW-1:0]  t_nxt;
	logic signed [PW-1:0]  r_nxt;
	int unsigned           s6_sh;

	always_comb begin
		case (op_s3.sh)
			q2hb_pkg::SH_NONE:  t_nxt = prod_s3;
			q2hb_pkg::SH_TWO:   t_nxt = PW'(q2hb_pkg::rnd_shift(q2hb_pkg::wide_t'(prod_s3), 2));
			q2hb_pkg::SH_FRAC:  t_nxt = PW'(q2hb_pkg::rnd_shift(q2hb_pkg::wide_t'(prod_s3), F));
			q2hb_pkg::SH_FRAC2: t_nxt = PW'(q2hb_pkg::rnd_shift(q2hb_pkg::wide_t'(prod_s3), F + 2));
			default:            t_nxt = prod_s3;
		endcase
	end

	always_comb begin
		s6_sh = q2hb_pkg::S6_FRAC + (op_s5.ext3 ? 3 : 2);
		if (op_s5.s6) begin
			r_nxt = PW'(q2hb_pkg::rnd_shift(q2hb_pkg::wide_t'(p6_s5), s6_sh));
		end else begin
			r_nxt = t_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			prod_s3 <= PW'(m1) * PW'(m2);
			op_s3   <= op;
			t_s4    <= t_nxt;
			op_s4   <= op_s3;
			// scaled terms fit in TW bits; other terms bypass this product
			p6_s5   <= P6W'(q2hb_pkg::S6_Q22) * P6W'($signed(t_s4[TW-1:0]));
			t_s5    <= t_s4;
			op_s5   <= op_s4;
			res_s6  <= r_nxt;
		end
	end

	assign res = res_s6;

endmodule

/* tb/sv/q2hb_basis_check.sv */
// ---------------------------------------------------------------------------
// q2hb_basis_check: result checker for the Q2 hierarchical basis evaluator
// Watches both channels. Every accepted point is expanded into the nine
// basis beats it must produce, and every result beat is compared with the
// oldest of them.
// ---------------------------------------------------------------------------
module q2hb_basis_check #(
	parameter int FRAC_BITS = 14
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic signed [15:0]  x_ref,
	input  logic signed [15:0]  y_ref,
	input  logic signed [31:0]  jinv_00,
	input  logic signed [31:0]  jinv_01,
	input  logic signed [31:0]  jinv_10,
	input  logic signed [31:0]  jinv_11,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic [3:0]          basis_index,
	input  logic signed [15:0]  basis_value,
	input  logic signed [31:0]  grad_x,
	input  logic signed [31:0]  grad_y,
	input  logic                last_basis,
	output int                  fail_count,
	output int                  pending_beats
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [71:0] wide_t;

	typedef struct packed {
		q2hb_pkg::basis_t    idx;
		logic signed [15:0]  value;
		logic signed [31:0]  gx;
		logic signed [31:0]  gy;
		logic                last;
	} basis_beat_t;

	localparam wide_t SQRT6_Q22 = 72'sd10273905;
	localparam int    SQRT6_FRAC = 22;
	localparam wide_t GRAD_MAX = 72'sd2147483647;
	localparam wide_t VALUE_MAX = 72'sd32767;

	basis_beat_t basis_beats_q[$];

	// round to nearest, ties away from zero
	function automatic wide_t round_half_away(input wide_t v, input int s);
		wide_t mag;
		mag = (v < 0) ? -v : v;
		mag = (mag + (wide_t'(1) <<< (s - 1))) >>> s;
		return (v < 0) ? -mag : mag;
	endfunction

	function automatic wide_t saturate(input wide_t v, input wide_t lo,
			input wide_t hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// t * sqrt(6) / 2^extra
	function automatic wide_t sqrt6_scale(input wide_t t, input int extra);
		return round_half_away(SQRT6_Q22 * t, SQRT6_FRAC + extra);
	endfunction

	// one row of the inverse Jacobian applied to a reference gradient
	function automatic wide_t map_to_element(input wide_t j0, input wide_t j1,
			input wide_t rdx, input wide_t rdy);
		wide_t acc;
		acc = j0 * saturate(rdx, -GRAD_MAX, GRAD_MAX)
			+ j1 * saturate(rdy, -GRAD_MAX, GRAD_MAX);
		return saturate(round_half_away(acc, FRAC_BITS), -GRAD_MAX - 1, GRAD_MAX);
	endfunction

	function automatic void predict_point(input wide_t x, input wide_t y,
			input wide_t j00, input wide_t j01, input wide_t j10, input wide_t j11);
		wide_t one, a, b, c, d, qx, qy;
		wide_t val[9];
		wide_t rdx[9];
		wide_t rdy[9];
		basis_beat_t beat;
		one = wide_t'(1) <<< FRAC_BITS;
		a = one - x;
		b = one + x;
		c = one - y;
		d = one + y;
		qx = round_half_away(x * x, FRAC_BITS) - one;
		qy = round_half_away(y * y, FRAC_BITS) - one;

		val[q2hb_pkg::B_VTX_SW] = round_half_away(a * c, FRAC_BITS + 2);
		val[q2hb_pkg::B_VTX_SE] = round_half_away(b * c, FRAC_BITS + 2);
		val[q2hb_pkg::B_VTX_NE] = round_half_away(b * d, FRAC_BITS + 2);
		val[q2hb_pkg::B_VTX_NW] = round_half_away(a * d, FRAC_BITS + 2);
		val[q2hb_pkg::B_EDGE_S] = sqrt6_scale(round_half_away(qx * c, FRAC_BITS), 3);
		val[q2hb_pkg::B_EDGE_E] = sqrt6_scale(round_half_away(qy * b, FRAC_BITS), 3);
		val[q2hb_pkg::B_EDGE_N] = sqrt6_scale(round_half_away(qx * d, FRAC_BITS), 3);
		val[q2hb_pkg::B_EDGE_W] = sqrt6_scale(round_half_away(qy * a, FRAC_BITS), 3);
		val[q2hb_pkg::B_CELL]   = round_half_away(qx * qy, FRAC_BITS);

		rdx[q2hb_pkg::B_VTX_SW] = round_half_away(-c, 2);
		rdx[q2hb_pkg::B_VTX_SE] = round_half_away(c, 2);
		rdx[q2hb_pkg::B_VTX_NE] = round_half_away(d, 2);
		rdx[q2hb_pkg::B_VTX_NW] = round_half_away(-d, 2);
		rdx[q2hb_pkg::B_EDGE_S] = sqrt6_scale(round_half_away(x * c, FRAC_BITS), 2);
		rdx[q2hb_pkg::B_EDGE_E] = sqrt6_scale(qy, 3);
		rdx[q2hb_pkg::B_EDGE_N] = sqrt6_scale(round_half_away(x * d, FRAC_BITS), 2);
		rdx[q2hb_pkg::B_EDGE_W] = sqrt6_scale(-qy, 3);
		rdx[q2hb_pkg::B_CELL]   = round_half_away(2 * x * qy, FRAC_BITS);

		rdy[q2hb_pkg::B_VTX_SW] = round_half_away(-a, 2);
		rdy[q2hb_pkg::B_VTX_SE] = round_half_away(-b, 2);
		rdy[q2hb_pkg::B_VTX_NE] = round_half_away(b, 2);
		rdy[q2hb_pkg::B_VTX_NW] = round_half_away(a, 2);
		rdy[q2hb_pkg::B_EDGE_S] = sqrt6_scale(-qx, 3);
		rdy[q2hb_pkg::B_EDGE_E] = sqrt6_scale(round_half_away(y * b, FRAC_BITS), 2);
		rdy[q2hb_pkg::B_EDGE_N] = sqrt6_scale(qx, 3);
		rdy[q2hb_pkg::B_EDGE_W] = sqrt6_scale(round_half_away(y * a, FRAC_BITS), 2);
		rdy[q2hb_pkg::B_CELL]   = round_half_away(2 * y * qx, FRAC_BITS);

		for (int k = 0; k < 9; k++) begin
			beat.idx   = q2hb_pkg::basis_t'(k);
			beat.value = 16'(saturate(val[k], -VALUE_MAX - 1, VALUE_MAX));
			beat.gx    = 32'(map_to_element(j00, j01, rdx[k], rdy[k]));
			beat.gy    = 32'(map_to_element(j10, j11, rdx[k], rdy[k]));
			beat.last  = (k == q2hb_pkg::B_CELL);
			basis_beats_q.push_back(beat);
		end
	endfunction

	always @(posedge clk) begin : watch
		basis_beat_t got;
		basis_beat_t want;
		if (!arst_n) begin
			basis_beats_q.delete();
			fail_count = 0;
			pending_beats = 0;
		end else begin
			if (in_valid && !in_stall)
				predict_point(x_ref, y_ref, jinv_00, jinv_01, jinv_10, jinv_11);
			if (out_valid && !out_stall) begin
				got = {basis_index, basis_value, grad_x, grad_y, last_basis};
				if (basis_beats_q.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: result beat with nothing pending: idx %0d val %0d "
							, $realtime, got.idx, got.value,
							"gx %0d gy %0d last %0b", got.gx, got.gy, got.last);
					fail_count++;
				end else begin
					want = basis_beats_q.pop_front();
					if (got.idx !== want.idx || got.value !== want.value ||
							got.gx !== want.gx || got.gy !== want.gy ||
							got.last !== want.last) begin
						if (fail_count < 10) begin
							$display("%0t: mismatch exp idx %0d val %0d gx %0d gy %0d last %0b",
								$realtime, want.idx, want.value, want.gx, want.gy, want.last);
							$display("%0t:          got idx %0d val %0d gx %0d gy %0d last %0b",
								$realtime, got.idx, got.value, got.gx, got.gy, got.last);
						end
						fail_count++;
					end
				end
			end
			pending_beats = basis_beats_q.size();
		end
	end

endmodule

/* tb/sv/q2_hier_basis_eval_unit_tb.sv */
// ---------------------------------------------------------------------------
// q2_hier_basis_eval_unit_tb: testbench top for the Q2 basis evaluator
// Drives reference points with inverse Jacobians into the block, throttles
// both channels, and leaves prediction and comparison to q2hb_basis_check.
// ---------------------------------------------------------------------------
module q2_hier_basis_eval_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = 14;
	localparam int LONG_HOLD_CYCLES = 200;
	localparam int DRAIN_CYCLES = 30;
	localparam logic signed [31:0] J_ONE = 32'sh00010000;
	localparam logic signed [31:0] J_MAX = 32'sh7FFFFFFF;
	localparam logic signed [31:0] J_MIN = 32'sh80000000;
	localparam logic signed [15:0] C_ONE = 16'sd16384;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// sender side
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [15:0] x_ref = '0;
	logic signed [15:0] y_ref = '0;
	logic signed [31:0] jinv_00 = '0;
	logic signed [31:0] jinv_01 = '0;
	logic signed [31:0] jinv_10 = '0;
	logic signed [31:0] jinv_11 = '0;

	// receiver side
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [3:0]         basis_index;
	logic signed [15:0] basis_value;
	logic signed [31:0] grad_x;
	logic signed [31:0] grad_y;
	logic               last_basis;

	int fail_count;
	int pending_beats;

	// throttle controls, written by the stimulus just after a rising edge and
	// read by the stall generator at falling edges
	bit idle_en = 1'b1;
	bit rx_hold_req = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	q2_hier_basis_eval_unit #(
		.COORD_FRAC_BITS(FRAC)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.x_ref      (x_ref),
		.y_ref      (y_ref),
		.jinv_00    (jinv_00),
		.jinv_01    (jinv_01),
		.jinv_10    (jinv_10),
		.jinv_11    (jinv_11),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.basis_index(basis_index),
		.basis_value(basis_value),
		.grad_x     (grad_x),
		.grad_y     (grad_y),
		.last_basis (last_basis)
	);

	q2hb_basis_check #(
		.FRAC_BITS(FRAC)
	) u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.x_ref        (x_ref),
		.y_ref        (y_ref),
		.jinv_00      (jinv_00),
		.jinv_01      (jinv_01),
		.jinv_10      (jinv_10),
		.jinv_11      (jinv_11),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.basis_index  (basis_index),
		.basis_value  (basis_value),
		.grad_x       (grad_x),
		.grad_y       (grad_y),
		.last_basis   (last_basis),
		.fail_count   (fail_count),
		.pending_beats(pending_beats)
	);

	// Hard stop, well beyond the slowest legal run (318 points, nine beats
	// each, each beat waiting out the longest random stall, plus gaps and
	// the long hold).
	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	// Receiver stall generator. Each pass picks a level and a run length and
	// holds it; each pass makes one assignment, at a falling edge.
	initial begin : rx_stall_gen
		bit lvl;
		int run;
		@(negedge clk);
		forever begin
			if (rx_hold_req) begin
				// long hold-off so the pipeline backs up into in_stall
				rx_hold_req = 1'b0;
				lvl = 1'b1;
				run = LONG_HOLD_CYCLES;
			end else if (!idle_en) begin
				lvl = 1'b0;
				run = 1;
			end else if ($urandom_range(0, 3) == 0) begin
				lvl = 1'b1;
				run = $urandom_range(1, 8);
			end else begin
				// free-running stretches of varying length
				lvl = 1'b0;
				run = $urandom_range(1, 24);
			end
			out_stall <= lvl;
			repeat (run) @(negedge clk);
		end
	end

	// Mostly inside the reference square, with grid points that hit the
	// corners and edge midpoints, and some raw 16-bit words for saturation.
	function automatic logic signed [15:0] pick_coord();
		int sel;
		int t;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return 16'($urandom);
		if (sel == 1) begin
			t = $urandom_range(0, 4);
			return 16'((t - 2) * 8192);
		end
		t = $urandom_range(0, 32768);
		return 16'(t - 16384);
	endfunction

	// Moderate scale most of the time, full 32-bit words and corner values
	// now and then to push the gradients into saturation.
	function automatic logic signed [31:0] pick_jinv();
		int sel;
		int t;
		sel = $urandom_range(0, 9);
		if (sel <= 1)
			return 32'($urandom);
		if (sel == 2) begin
			case ($urandom_range(0, 4))
				0: return '0;
				1: return J_MAX;
				2: return J_MIN;
				3: return J_ONE;
				default: return -J_ONE;
			endcase
		end
		t = $urandom_range(0, 2097152);
		return 32'(t - 1048576);
	endfunction

	// One input beat: payload set at a falling edge, held until accepted.
	// Afterwards, while idle_en is set, an optional random gap with in_valid low.
	task automatic offer_point(input logic signed [15:0] xv, input logic signed [15:0] yv,
			input logic signed [31:0] j00, input logic signed [31:0] j01,
			input logic signed [31:0] j10, input logic signed [31:0] j11);
		int gap;
		@(negedge clk);
		x_ref   <= xv;
		y_ref   <= yv;
		jinv_00 <= j00;
		jinv_01 <= j01;
		jinv_10 <= j10;
		jinv_11 <= j11;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall !== 1'b0);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 8);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic offer_random_points(input int count);
		repeat (count)
			offer_point(pick_coord(), pick_coord(),
				pick_jinv(), pick_jinv(), pick_jinv(), pick_jinv());
	endtask

	// Sender goes quiet until every predicted beat has come out.
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (pending_beats == 0);
	endtask

	initial begin : stimulus
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Directed: center, the four corners, interior points, values that
		// round on a tie, points outside the square (value saturation) and
		// extreme Jacobians (gradient saturation).
		offer_point('0, '0, J_ONE, '0, '0, J_ONE);
		offer_point(-C_ONE, -C_ONE, J_ONE, '0, '0, J_ONE);
		offer_point(C_ONE, -C_ONE, J_ONE, '0, '0, J_ONE);
		offer_point(C_ONE, C_ONE, J_ONE, '0, '0, J_ONE);
		offer_point(-C_ONE, C_ONE, J_ONE, '0, '0, J_ONE);
		offer_point(16'sd8192, -16'sd8192, 32'sh00020000, '0, '0, 32'sh00020000);
		offer_point(16'sd1, -16'sd1, J_ONE, 32'sh00008000, -32'sh00008000, J_ONE);
		offer_point(16'sh8000, 16'sh8000, J_ONE, '0, '0, J_ONE);
		offer_point(16'sh7FFF, 16'sh7FFF, J_ONE, '0, '0, J_ONE);
		offer_point(16'sh7FFF, 16'sh8000, J_ONE, '0, '0, J_ONE);
		offer_point(16'sh8000, 16'sh7FFF, J_MAX, J_MAX, J_MAX, J_MAX);
		offer_point(16'sh8000, 16'sh8000, J_MIN, J_MIN, J_MIN, J_MIN);
		offer_point(C_ONE, '0, J_MAX, J_MIN, J_MIN, J_MAX);
		offer_point('0, C_ONE, '0, '0, '0, '0);
		offer_point(16'sd12345, -16'sd6789, 32'shFFFFFFFF, 32'sd1, -32'sd1, 32'sd2);
		offer_point(-16'sd3, 16'sd5, 32'sh55555555, 32'shAAAAAAAA,
			32'sh0F0F0F0F, 32'shF0F0F0F0);
		offer_point(-16'sd16383, 16'sd16383, J_ONE, J_ONE, J_ONE, J_ONE);
		offer_point(16'sd24576, -16'sd24576, -J_ONE, '0, '0, -J_ONE);

		// random with idling on both sides
		offer_random_points(120);
		drain_results();

		// receiver holds off while the sender keeps streaming back to back
		idle_en = 1'b0;
		rx_hold_req = 1'b1;
		offer_random_points(30);
		idle_en = 1'b1;

		offer_random_points(90);
		drain_results();

		// closing stretch at full rate, no idling anywhere
		idle_en = 1'b0;
		offer_random_points(60);
		drain_results();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_beats == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/q2hb_pkg.sv
rtl/core/q2hb_lane.sv
rtl/core/q2_hier_basis_eval_unit.sv
tb/sv/q2hb_basis_check.sv
tb/sv/q2_hier_basis_eval_unit_tb.sv
